/* hw/rtl/dtl_pkg.sv */
package dtl_pkg;

  localparam int ENTRIES_DEF = 64;
  localparam int KEY_W = 64;
  localparam int TIME_W = 32;
  localparam int HIT_W = 32;
  localparam logic [HIT_W-1:0] HIT_MAX = '1;

  typedef enum logic [1:0] {
    OP_LEARN  = 2'd0,
    OP_RECALL = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_RSVD   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    OC_UPDATED = 3'd0,
    OC_INSERTED = 3'd1,
    OC_EVICTED = 3'd2,
    OC_MISS = 3'd3,
    OC_CLEARED = 3'd4
  } outcome_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SUM,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0] k0;
    logic [KEY_W-1:0] k1;
    logic [KEY_W-1:0] k2;
    logic [KEY_W-1:0] k3;
    logic [TIME_W-1:0] ts;
    logic [HIT_W-1:0] hits;
    logic valid;
  } entry_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic clear;
    logic write;
    logic touch;
    logic shift;
  } cell_ctl_t;

endpackage

/* hw/rtl/dtl_cell.sv */
module dtl_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  dtl_pkg::cell_ctl_t   ctl,
  input  logic                 sel,
  input  dtl_pkg::entry_t      wdata,
  input  dtl_pkg::entry_t      prev,
  output dtl_pkg::entry_t      cur
);

  dtl_pkg::entry_t ent;

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      ent.valid <= 1'b0;
    end else if (ctl.shift) begin
      ent <= prev;
    end else if (ctl.write && sel) begin
      ent <= wdata;
    end else if (ctl.touch && sel) begin
      ent.ts <= wdata.ts;
      if (ent.hits != dtl_pkg::HIT_MAX) begin
        ent.hits <= ent.hits + 1'b1;
      end
    end
  end

  assign cur = ent;

endmodule

/* hw/rtl/digest_table_lru_learn_recall.sv */
// channel  | ports                                         | handshake
// command  | op key_w0..key_w3 now                         | start / busy
// result   | outcome found slot_index used_count           | done strobe
//          | live_count hits_total recall_hits             |
// For a learn or recall item the ring of cells rotates once
// to search for the key, free slot and oldest entry, and once more to sum.
// A clear skips both rotations. rst empties the table and zeroes the recall count.
// The result strobe lasts one cycle; the receiver cannot stall it.
module digest_table_lru_learn_recall #(
  parameter int ENTRIES = dtl_pkg::ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op,
  input  logic [63:0] key_w0,
  input  logic [63:0] key_w1,
  input  logic [63:0] key_w2,
  input  logic [63:0] key_w3,
  input  logic [31:0] now,
  output logic        done,
  output logic [2:0]  outcome,
  output logic        found,
  output logic [5:0]  slot_index,
  output logic [6:0]  used_count,
  output logic [6:0]  live_count,
  output logic [37:0] hits_total,
  output logic [31:0] recall_hits
);

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int SW = CW + dtl_pkg::HIT_W;

  dtl_pkg::state_t state, state_next;
  dtl_pkg::cell_ctl_t ctl;
  dtl_pkg::entry_t cells [ENTRIES];
  dtl_pkg::entry_t wdata;

  logic [1:0]  op_q;
  logic [63:0] k0, k1, k2, k3;
  logic [31:0] now_q;
  logic [CW-1:0] fill;
  logic [31:0] rcnt;
  logic [IW-1:0] pos;
  logic [IW-1:0] pos_inc;
  logic [IW:0]   cnt;
  logic          pass;
  logic          hit, have_free;
  logic [IW-1:0] hit_idx, free_idx, old_idx;
  logic [31:0]   oldest;
  logic [CW-1:0] active;
  logic [SW-1:0] hsum;
  logic [IW-1:0] target;
  logic [IW-1:0] slot_q;
  logic          do_write, do_touch;
  logic          in_range;
  logic          appended;
  dtl_pkg::entry_t head;

  assign head = cells[0];
  assign in_range = ({1'b0, pos} < (IW + 1)'(fill)) || (CW > IW + 1);
  assign busy = (state != dtl_pkg::ST_IDLE);
  assign pos_inc = (pos == IW'(ENTRIES - 1)) ? '0 : pos + 1'b1;

  // Cell i holds slot (i + pos) mod ENTRIES; cell 0 is the inspection point.
  genvar g;
  generate
    for (g = 0; g < ENTRIES; g++) begin : g_cell
      dtl_cell u_cell (
        .clk(clk), .rst(rst), .ctl(ctl),
        .sel(IW'(g) == target),
        .wdata(wdata),
        .prev(cells[(g + 1) % ENTRIES]),
        .cur(cells[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dtl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl = '0;
    case (state)
      dtl_pkg::ST_IDLE: begin
        if (start) begin
          state_next = (dtl_pkg::op_t'(op) == dtl_pkg::OP_CLEAR) ?
                       dtl_pkg::ST_DONE : dtl_pkg::ST_SCAN;
          ctl.clear = (dtl_pkg::op_t'(op) == dtl_pkg::OP_CLEAR);
        end
      end
      dtl_pkg::ST_SCAN: begin
        ctl.shift = 1'b1;
        if (cnt == (IW + 1)'(ENTRIES - 1)) begin
          state_next = dtl_pkg::ST_SUM;
        end
      end
      dtl_pkg::ST_SUM: begin
        ctl.shift = !pass;
        ctl.write = pass && do_write;
        ctl.touch = pass && do_touch;
        if (!pass && cnt == (IW + 1)'(ENTRIES - 1)) begin
          state_next = dtl_pkg::ST_DONE;
        end
      end
      dtl_pkg::ST_DONE: begin
        state_next = dtl_pkg::ST_IDLE;
      end
      default: state_next = dtl_pkg::ST_IDLE;
    endcase
  end

  // Decide the target slot once the search rotation completes.
  always_comb begin
    do_touch = hit && (op_q == dtl_pkg::OP_LEARN || op_q == dtl_pkg::OP_RECALL);
    do_write = !hit && op_q == dtl_pkg::OP_LEARN;
    if (hit) begin
      target = hit_idx;
    end else if (have_free) begin
      target = free_idx;
    end else if (fill < CW'(ENTRIES)) begin
      target = IW'(fill);
    end else begin
      target = old_idx;
    end
    wdata.k0 = k0;
    wdata.k1 = k1;
    wdata.k2 = k2;
    wdata.k3 = k3;
    wdata.ts = now_q;
    wdata.hits = 32'd1;
    wdata.valid = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      fill <= '0;
      rcnt <= '0;
      pos <= '0;
      cnt <= '0;
      pass <= 1'b0;
    end else begin
      done <= (state == dtl_pkg::ST_DONE);
      case (state)
        dtl_pkg::ST_IDLE: begin
          if (start) begin
            op_q <= op;
            k0 <= key_w0;
            k1 <= key_w1;
            k2 <= key_w2;
            k3 <= key_w3;
            now_q <= now;
            cnt <= '0;
            pos <= '0;
            hit <= 1'b0;
            have_free <= 1'b0;
            hit_idx <= '0;
            free_idx <= '0;
            old_idx <= '0;
            oldest <= now;
            active <= '0;
            hsum <= '0;
            if (dtl_pkg::op_t'(op) == dtl_pkg::OP_CLEAR) begin
              fill <= '0;
            end
          end
        end
        dtl_pkg::ST_SCAN: begin
          if (in_range && head.valid && !hit && head.k0 == k0 && head.k1 == k1 &&
              head.k2 == k2 && head.k3 == k3) begin
            hit <= 1'b1;
            hit_idx <= pos;
          end
          if (in_range && !head.valid && !have_free) begin
            have_free <= 1'b1;
            free_idx <= pos;
          end
          if (head.ts < oldest) begin
            oldest <= head.ts;
            old_idx <= pos;
          end
          pos <= pos_inc;
          cnt <= (cnt == (IW + 1)'(ENTRIES - 1)) ? '0 : cnt + 1'b1;
          pass <= (cnt == (IW + 1)'(ENTRIES - 1));
        end
        dtl_pkg::ST_SUM: begin
          if (pass) begin
            pass <= 1'b0;
            slot_q <= target;
            if (do_write && !have_free && fill < CW'(ENTRIES)) begin
              fill <= fill + 1'b1;
            end
            if (do_touch && op_q == dtl_pkg::OP_RECALL && rcnt != dtl_pkg::HIT_MAX) begin
              rcnt <= rcnt + 1'b1;
            end
            cnt <= '0;
          end else begin
            if (in_range && head.valid) begin
              active <= active + 1'b1;
              hsum <= hsum + SW'(head.hits);
            end
            cnt <= cnt + 1'b1;
          end
          // pos wraps with every shift so slot numbering stays aligned
          if (ctl.shift) begin
            pos <= pos_inc;
          end
        end
        dtl_pkg::ST_DONE: begin
          found <= hit && (op_q == dtl_pkg::OP_LEARN || op_q == dtl_pkg::OP_RECALL);
          slot_index <= (op_q == dtl_pkg::OP_LEARN || (op_q == dtl_pkg::OP_RECALL && hit)) ?
                        6'(slot_q) : '0;
          if (op_q == dtl_pkg::OP_CLEAR) begin
            outcome <= dtl_pkg::OC_CLEARED;
          end else if (hit && (op_q == dtl_pkg::OP_LEARN || op_q == dtl_pkg::OP_RECALL)) begin
            outcome <= dtl_pkg::OC_UPDATED;
          end else if (op_q == dtl_pkg::OP_LEARN) begin
            outcome <= (have_free || appended) ? dtl_pkg::OC_INSERTED
                                               : dtl_pkg::OC_EVICTED;
          end else begin
            outcome <= dtl_pkg::OC_MISS;
          end
          used_count <= 7'(fill);
          live_count <= (op_q == dtl_pkg::OP_CLEAR) ? 7'd0 : 7'(active);
          hits_total <= (op_q == dtl_pkg::OP_CLEAR) ? 38'd0 : 38'(hsum);
          recall_hits <= rcnt;
        end
        default: ;
      endcase
    end
  end

  // Evicted only when fill was full before the write; fill reached ENTRIES
  // by an append in this item means it was not.
  always_ff @(posedge clk) begin
    if (rst || (state == dtl_pkg::ST_IDLE)) begin
      appended <= 1'b0;
    end else if (state == dtl_pkg::ST_SUM && pass && do_write && !have_free &&
                 fill < CW'(ENTRIES)) begin
      appended <= 1'b1;
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("busy during result");
  a_fill_cap: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(ENTRIES)) else $error("fill level overflow");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("item accepted without busy");

endmodule
